// File: sv/pmst_pkg.sv
// Package with the types, constants, microcode table and helpers of the spanning tree block.
`timescale 1ns / 1ps

package pmst_pkg;

  localparam int MAX_NODES = 16;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int WEIGHT_W  = 15;
  localparam int TOTAL_W   = 19;
  localparam int ADDR_W    = 2 * NODE_W;
  localparam int RAM_DEPTH = MAX_NODES * MAX_NODES;
  localparam int PC_W      = 3;

  // Largest weight code; it never wins a comparison, so it behaves as no edge.
  localparam logic [WEIGHT_W-1:0] WEIGHT_CAP = WEIGHT_W'(32767);
  localparam logic [CNT_W-1:0]    N_MAX      = CNT_W'(MAX_NODES);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RUN   = 1'b1;

  typedef struct packed {
    logic                op;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic [WEIGHT_W-1:0] edge_cost;
    logic [TOTAL_W-1:0]  total_cost;
    logic                unreachable;
    logic                last;
  } out_item_t;

  typedef enum logic [1:0] {
    E_NONE,
    E_START,
    E_ROUND
  } emit_t;

  typedef enum logic [1:0] {
    H_NONE,
    H_NO_RUN,
    H_OUT_BUSY,
    H_SCAN_MORE
  } hold_t;

  typedef enum logic [1:0] {
    J_NEVER,
    J_ALWAYS,
    J_DONE,
    J_NOT_FOUND
  } jmp_t;

  typedef struct packed {
    logic            in_rdy;
    logic            clr_scan;
    logic            issue;
    emit_t           emit;
    hold_t           hold;
    jmp_t            jmp;
    logic [PC_W-1:0] tgt;
  } ctl_t;

  typedef struct packed {
    logic run_go;
    logic out_busy;
    logic scan_more;
    logic done;
    logic not_found;
  } stat_t;

  localparam logic [PC_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] ST_EMIT0 = 3'd1;
  localparam logic [PC_W-1:0] ST_CHK   = 3'd2;
  localparam logic [PC_W-1:0] ST_INIT  = 3'd3;
  localparam logic [PC_W-1:0] ST_SCAN  = 3'd4;
  localparam logic [PC_W-1:0] ST_DRAIN = 3'd5;
  localparam logic [PC_W-1:0] ST_EMITR = 3'd6;
  localparam logic [PC_W-1:0] ST_LOOP  = 3'd7;

  // Control store: one word per step of the run program.
  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    w = '{in_rdy: 1'b0, clr_scan: 1'b0, issue: 1'b0, emit: E_NONE,
          hold: H_NONE, jmp: J_NEVER, tgt: ST_IDLE};
    unique case (pc)
      ST_IDLE: begin
        w.in_rdy = 1'b1;
        w.hold   = H_NO_RUN;
      end
      ST_EMIT0: begin
        w.emit = E_START;
        w.hold = H_OUT_BUSY;
      end
      ST_CHK: begin
        w.jmp = J_DONE;
        w.tgt = ST_IDLE;
      end
      ST_INIT: begin
        w.clr_scan = 1'b1;
      end
      ST_SCAN: begin
        w.issue = 1'b1;
        w.hold  = H_SCAN_MORE;
      end
      ST_DRAIN: begin
        w.hold = H_NONE;
      end
      ST_EMITR: begin
        w.emit = E_ROUND;
        w.hold = H_OUT_BUSY;
        w.jmp  = J_NOT_FOUND;
        w.tgt  = ST_IDLE;
      end
      ST_LOOP: begin
        w.jmp = J_ALWAYS;
        w.tgt = ST_CHK;
      end
      default: begin
        w.jmp = J_ALWAYS;
        w.tgt = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  // The matrix is symmetric, so each pair is kept once with the smaller node first.
  function automatic logic [ADDR_W-1:0] pair_addr(input logic [NODE_W-1:0] a,
                                                  input logic [NODE_W-1:0] b);
    logic [ADDR_W-1:0] r;
    if (a < b) begin
      r = {a, b};
    end else begin
      r = {b, a};
    end
    return r;
  endfunction

endpackage

// File: sv/prim_minimum_spanning_tree.sv
// Top level of the minimum spanning tree block: sequencer and datapath.
//
// Usage. Input transfers on in_valid/in_ready carry an op and a node pair with a weight.
// A write op stores the weight for both directions of the pair and gives no
// result; a pair naming the same node twice is ignored. A run op grows a tree from node 0
// over the first node_count nodes and gives one result transfer per node on
// out_valid/out_ready: node 0 first, then one joined node per round with its edge cost
// and running total. A round that finds no usable edge gives a single result with
// unreachable and last set and ends the run. Weights of zero or 32767 count as no edge.
// A run gives the start result, then each round reads all n*n entries of the matrix,
// where n is the active node count: the matrix is read one entry per cycle through the
// single read port of the weight memory. in_ready is low for the whole run.
// The result sits in an output register; a stalled receiver holds the sequencer at its
// emit step and no result is lost. Reset clears the sequencer, the tree state and the
// output valid flag and sets node_count to 1; the weight memory is not cleared and holds
// nothing useful until written. node_count is written through cfg_we/cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
`timescale 1ns / 1ps

module prim_minimum_spanning_tree import pmst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  ctl_t  ctl;
  stat_t st;

  // The control word drives the datapath; status flags feed back for holds and jumps.
  pmst_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .st   (st),
    .ctl  (ctl)
  );

  pmst_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_data  (in_data),
    .ctl      (ctl),
    .st       (st),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Input transfers are only taken at the idle step of the program.
  assign in_ready = ctl.in_rdy;

endmodule

// File: sv/pmst_ram.sv
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module pmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/pmst_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps

module pmst_seq import pmst_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t st,
  output ctl_t  ctl
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            hold;
  logic            jump;

  assign ctl = ucode(pc_r);

  always_comb begin
    unique case (ctl.hold)
      H_NONE:      hold = 1'b0;
      H_NO_RUN:    hold = !st.run_go;
      H_OUT_BUSY:  hold = st.out_busy;
      H_SCAN_MORE: hold = st.scan_more;
      default:     hold = 1'b0;
    endcase
    unique case (ctl.jmp)
      J_NEVER:     jump = 1'b0;
      J_ALWAYS:    jump = 1'b1;
      J_DONE:      jump = st.done;
      J_NOT_FOUND: jump = st.not_found;
      default:     jump = 1'b0;
    endcase
    if (hold) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = ctl.tgt;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: sv/pmst_dp.sv
// Datapath: weight store, scan counters, minimum search, tree state and result register.
`timescale 1ns / 1ps

module pmst_dp import pmst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             in_valid,
  input  in_item_t         in_data,
  input  ctl_t             ctl,
  output stat_t            st,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  logic [CNT_W-1:0]     node_count_r;
  logic [CNT_W-1:0]     n_act;
  logic [NODE_W-1:0]    nm1;
  logic [MAX_NODES-1:0] visited_r, visited_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic [TOTAL_W-1:0]   sum;
  logic [CNT_W-1:0]     round_r, round_nxt;
  logic [NODE_W-1:0]    i_r, i_nxt, j_r, j_nxt;
  logic                 elig_d_r, elig_d_nxt;
  logic [NODE_W-1:0]    j_d_r, j_d_nxt;
  logic [WEIGHT_W-1:0]  best_r, best_nxt;
  logic [NODE_W-1:0]    pick_r, pick_nxt;
  logic                 found_r, found_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;
  logic                 accept;
  logic                 out_free;
  logic                 fire;
  logic                 last_pair;
  logic                 ram_we;
  logic [WEIGHT_W-1:0]  rd_data;

  assign accept   = in_valid && ctl.in_rdy;
  assign out_free = !out_valid_r || out_ready;
  assign fire     = (ctl.emit != E_NONE) && out_free;
  assign ram_we   = accept && (in_data.op == OP_WRITE) && (in_data.node_a != in_data.node_b);

  always_comb begin
    if (node_count_r == '0) begin
      n_act = CNT_W'(1);
    end else if (node_count_r > N_MAX) begin
      n_act = N_MAX;
    end else begin
      n_act = node_count_r;
    end
  end

  assign nm1       = NODE_W'(n_act - CNT_W'(1));
  assign last_pair = (i_r == nm1) && (j_r == nm1);
  assign sum       = total_r + TOTAL_W'(best_r);

  pmst_ram #(
    .WIDTH(WEIGHT_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pair_addr(in_data.node_a, in_data.node_b)),
    .wdata(in_data.weight),
    .raddr(pair_addr(i_r, j_r)),
    .rdata(rd_data)
  );

  always_comb begin
    visited_nxt   = visited_r;
    total_nxt     = total_r;
    round_nxt     = round_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    elig_d_nxt    = 1'b0;
    j_d_nxt       = j_d_r;
    best_nxt      = best_r;
    pick_nxt      = pick_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    if (accept && (in_data.op == OP_RUN)) begin
      visited_nxt = MAX_NODES'(1);
      total_nxt   = '0;
      round_nxt   = CNT_W'(1);
    end

    if (ctl.clr_scan) begin
      i_nxt     = '0;
      j_nxt     = '0;
      best_nxt  = WEIGHT_CAP;
      found_nxt = 1'b0;
    end

    // The read issued last cycle returns now; strict compare keeps the first minimum.
    if (elig_d_r && (rd_data != '0) && (rd_data < best_r)) begin
      best_nxt  = rd_data;
      pick_nxt  = j_d_r;
      found_nxt = 1'b1;
    end

    if (ctl.issue) begin
      elig_d_nxt = visited_r[i_r] && !visited_r[j_r];
      j_d_nxt    = j_r;
      if (j_r == nm1) begin
        j_nxt = '0;
        i_nxt = i_r + NODE_W'(1);
      end else begin
        j_nxt = j_r + NODE_W'(1);
      end
    end

    if (fire) begin
      out_valid_nxt = 1'b1;
      if (ctl.emit == E_START) begin
        out_nxt = '{node: '0, edge_cost: '0, total_cost: '0, unreachable: 1'b0,
                    last: (n_act == CNT_W'(1))};
      end else if (found_r) begin
        out_nxt = '{node: pick_r, edge_cost: best_r, total_cost: sum, unreachable: 1'b0,
                    last: ((round_r + CNT_W'(1)) == n_act)};
        visited_nxt = visited_r | (MAX_NODES'(1) << pick_r);
        total_nxt   = sum;
        round_nxt   = round_r + CNT_W'(1);
      end else begin
        out_nxt = '{node: '0, edge_cost: '0, total_cost: total_r, unreachable: 1'b1,
                    last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNT_W'(1);
      visited_r    <= '0;
      total_r      <= '0;
      round_r      <= '0;
      i_r          <= '0;
      j_r          <= '0;
      elig_d_r     <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_data;
      end
      visited_r   <= visited_nxt;
      total_r     <= total_nxt;
      round_r     <= round_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      elig_d_r    <= elig_d_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_d_r  <= j_d_nxt;
    best_r <= best_nxt;
    pick_r <= pick_nxt;
    out_r  <= out_nxt;
  end

  assign st.run_go    = in_valid && (in_data.op == OP_RUN);
  assign st.out_busy  = !out_free;
  assign st.scan_more = !last_pair;
  assign st.done      = (round_r >= n_act);
  assign st.not_found = !found_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A node joined to the tree was not already in it.
  a_pick_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (ctl.emit == E_ROUND) && found_r) |-> !visited_r[pick_r])
    else $error("joined node already visited");

  // While a run is in progress the start node is always in the tree.
  a_root_visited: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.in_rdy |-> visited_r[0])
    else $error("start node missing from tree during run");

  // A compare slot only follows a matrix read.
  a_elig_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    elig_d_r |-> $past(ctl.issue))
    else $error("compare without a preceding read");

endmodule

// File: verif/tb_prim_minimum_spanning_tree.sv
// Self-checking testbench for the spanning tree block: directed cases, then random traffic.
`timescale 1ns / 1ps

module tb_prim_minimum_spanning_tree;
  import pmst_pkg::*;

  // Clock and reset. The clock runs from time zero; reset is held low from the
  // start and then released once for the rest of the run.
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;

  prim_minimum_spanning_tree dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Shadow copy of the block's state. The weight array mirrors the full
  // matrix; cfg_nodes holds the raw register value, clamped only when a run
  // is predicted, exactly as the block is meant to treat it.
  logic [WEIGHT_W-1:0] edge_w [MAX_NODES][MAX_NODES];
  logic [CNT_W-1:0]    cfg_nodes;

  // Results still owed by the block, oldest first.
  out_item_t tree_expect[$];
  int        fail_count;

  // Per-phase switches that turn off the random gaps on either side, so that
  // some stretches of the run see back-to-back transfers.
  bit quiet_in;
  bit quiet_out;

  function automatic void expect_result(int node, int cost, int total, bit unr, bit fin);
    out_item_t r;
    r.node        = NODE_W'(node);
    r.edge_cost   = WEIGHT_W'(cost);
    r.total_cost  = TOTAL_W'(total);
    r.unreachable = unr;
    r.last        = fin;
    tree_expect.push_back(r);
  endfunction

  // A write stores the weight for both directions; a self pair is dropped.
  function automatic void store_edge(in_item_t item);
    if (item.node_a != item.node_b) begin
      edge_w[item.node_a][item.node_b] = item.weight;
      edge_w[item.node_b][item.node_a] = item.weight;
    end
  endfunction

  // Grows the tree from node 0 over the active nodes. Each round scans the
  // matrix in row-major order and keeps the first strictly cheaper edge, so
  // ties fall to the earliest visited row and then the earliest column. A
  // weight of zero is no edge, and the largest code never beats the initial
  // bound, so it is no edge either. When a round finds nothing the run stops
  // with a single unreachable result carrying the total so far.
  function automatic void grow_tree();
    int                 n;
    int                 best;
    int                 pick;
    int                 total;
    int                 w;
    bit                 found;
    logic [MAX_NODES-1:0] joined;
    if (cfg_nodes == 0) begin
      n = 1;
    end else if (cfg_nodes > MAX_NODES) begin
      n = MAX_NODES;
    end else begin
      n = int'(cfg_nodes);
    end
    joined = MAX_NODES'(1);
    total  = 0;
    expect_result(0, 0, 0, 1'b0, n == 1);
    for (int round = 1; round < n; round++) begin
      best  = int'(WEIGHT_CAP);
      pick  = 0;
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (joined[NODE_W'(i)]) begin
          for (int j = 0; j < n; j++) begin
            w = int'(edge_w[NODE_W'(i)][NODE_W'(j)]);
            if (!joined[NODE_W'(j)] && w != 0 && w < best) begin
              best  = w;
              pick  = j;
              found = 1'b1;
            end
          end
        end
      end
      if (!found) begin
        expect_result(0, 0, total, 1'b1, 1'b1);
        return;
      end
      joined[NODE_W'(pick)] = 1'b1;
      total        = (total + best) % (1 << TOTAL_W);
      expect_result(pick, best, total, 1'b0, round + 1 == n);
    end
  endfunction

  function automatic in_item_t make_item(logic op, int a, int b, int w);
    in_item_t item;
    item.op     = op;
    item.node_a = NODE_W'(a);
    item.node_b = NODE_W'(b);
    item.weight = WEIGHT_W'(w);
    return item;
  endfunction

  // Weight mix: plenty of small values so that ties are common, some
  // missing edges, some of the never-eligible code, some of the largest
  // usable weight, and the rest spread over the whole field.
  function automatic int draw_weight();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return 0;
    if (sel < 20) return int'(WEIGHT_CAP);
    if (sel < 25) return int'(WEIGHT_CAP) - 1;
    if (sel < 75) return $urandom_range(1, 20);
    return $urandom_range(0, (1 << WEIGHT_W) - 1);
  endfunction

  // Sends one item: an optional gap, then valid held high with the payload
  // fixed until the transfer. Prediction happens at the accepting edge.
  task automatic send_item(input in_item_t item);
    int unsigned gap;
    gap = quiet_in ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (item.op == OP_RUN) begin
      grow_tree();
    end else begin
      store_edge(item);
    end
  endtask

  // Lets the block go idle: no input offered, every owed result received,
  // then a wait for the run to close off after its final result.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (tree_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_node_count(input int value);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_data  <= CNT_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_nodes  = CNT_W'(value);
  endtask

  // Straight after reset the register holds one node, so a run touches no
  // weight at all and must give node 0 alone, flagged as the last result.
  task automatic test_single_node_after_reset();
    send_item(make_item(OP_RUN, 0, 0, 0));
  endtask

  // Every pair of the matrix is written once before any run can read it,
  // since the weight memory holds nothing defined after reset. The order
  // of the two nodes is swapped at random so both fields see every value.
  task automatic test_fill_matrix();
    for (int a = 0; a < MAX_NODES; a++) begin
      for (int b = a + 1; b < MAX_NODES; b++) begin
        if ($urandom_range(0, 1) != 0) begin
          send_item(make_item(OP_WRITE, a, b, draw_weight()));
        end else begin
          send_item(make_item(OP_WRITE, b, a, draw_weight()));
        end
      end
    end
  endtask

  // Register extremes: zero must behave as one node, and the all-ones
  // value must saturate to the full sixteen nodes.
  task automatic test_node_count_clamp();
    set_node_count(0);
    send_item(make_item(OP_RUN, 15, 15, (1 << WEIGHT_W) - 1));
    set_node_count((1 << CNT_W) - 1);
    send_item(make_item(OP_RUN, 0, 0, 0));
  endtask

  // Two nodes and a single edge: the never-eligible code, the largest
  // usable weight, an ignored self pair, and a cleared edge.
  task automatic test_weight_extremes();
    set_node_count(2);
    send_item(make_item(OP_WRITE, 0, 1, int'(WEIGHT_CAP)));
    send_item(make_item(OP_RUN, 0, 0, 0));
    send_item(make_item(OP_WRITE, 1, 0, int'(WEIGHT_CAP) - 1));
    send_item(make_item(OP_RUN, 0, 0, 0));
    send_item(make_item(OP_WRITE, 1, 1, 9));
    send_item(make_item(OP_RUN, 0, 0, 0));
    send_item(make_item(OP_WRITE, 0, 1, 0));
    send_item(make_item(OP_RUN, 0, 0, 0));
  endtask

  // Four nodes joined by equal weights: each round must pick the first
  // candidate pair in row-major order.
  task automatic test_equal_weights();
    set_node_count(4);
    send_item(make_item(OP_WRITE, 0, 1, 7));
    send_item(make_item(OP_WRITE, 2, 0, 7));
    send_item(make_item(OP_WRITE, 0, 3, 7));
    send_item(make_item(OP_WRITE, 1, 2, 7));
    send_item(make_item(OP_WRITE, 3, 1, 7));
    send_item(make_item(OP_WRITE, 2, 3, 7));
    send_item(make_item(OP_RUN, 0, 0, 0));
  endtask

  // Node 4 is cut off from the rest, so the run ends early with the
  // unreachable flag and the total reached so far.
  task automatic test_disconnected_graph();
    set_node_count(5);
    send_item(make_item(OP_WRITE, 4, 0, 0));
    send_item(make_item(OP_WRITE, 1, 4, 0));
    send_item(make_item(OP_WRITE, 4, 2, 0));
    send_item(make_item(OP_WRITE, 3, 4, 0));
    send_item(make_item(OP_RUN, 0, 0, 0));
  endtask

  // Random traffic in phases. Each phase picks a node count (mostly small
  // to keep runs short, one phase at the full size, one at zero and one
  // above the limit) and its own idling, then sends a mix of writes within
  // the active nodes, writes anywhere, self pairs and runs.
  task automatic test_random_traffic();
    int unsigned sel;
    int          n;
    int          a;
    int          b;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        1:       n = MAX_NODES;
        3:       n = 0;
        5:       n = $urandom_range(MAX_NODES + 1, (1 << CNT_W) - 1);
        default: n = $urandom_range(2, 9);
      endcase
      set_node_count(n);
      if (n == 0) begin
        n = 1;
      end else if (n > MAX_NODES) begin
        n = MAX_NODES;
      end
      quiet_in  = (phase == 0) || ($urandom_range(0, 3) == 0);
      quiet_out = (phase == 0) || ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 24; k++) begin
        sel = $urandom_range(0, 99);
        a   = $urandom_range(0, n - 1);
        b   = $urandom_range(0, n - 1);
        if (sel < 25) begin
          send_item(make_item(OP_RUN, $urandom_range(0, MAX_NODES - 1),
                              $urandom_range(0, MAX_NODES - 1),
                              $urandom_range(0, (1 << WEIGHT_W) - 1)));
        end else if (sel < 80) begin
          send_item(make_item(OP_WRITE, a, b, draw_weight()));
        end else if (sel < 92) begin
          send_item(make_item(OP_WRITE, $urandom_range(0, MAX_NODES - 1),
                              $urandom_range(0, MAX_NODES - 1), draw_weight()));
        end else begin
          send_item(make_item(OP_WRITE, a, a, draw_weight()));
        end
      end
    end
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
  endtask

  // Result side: a random number of stall cycles before each transfer,
  // then ready held high until the transfer happens. The low phase is only
  // scheduled when there is a gap, so ready is never assigned twice in one
  // step.
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      gap = quiet_out ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Every result transfer is matched against the oldest owed result.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tree_expect.size() == 0) begin
        $error("result transfer with nothing owed: node %0d total %0d",
               out_data.node, out_data.total_cost);
        fail_count++;
      end else begin
        want = tree_expect.pop_front();
        check_field("node", 32'(want.node), 32'(out_data.node));
        check_field("edge_cost", 32'(want.edge_cost), 32'(out_data.edge_cost));
        check_field("total_cost", 32'(want.total_cost), 32'(out_data.total_cost));
        check_field("unreachable", 32'(want.unreachable), 32'(out_data.unreachable));
        check_field("last", 32'(want.last), 32'(out_data.last));
      end
    end
  end

  // Watchdog: far beyond the slowest correct run of this stimulus, even if
  // every item were a full-size run with the receiver stalling throughout.
  initial begin
    #100_000_000;
    $display("tb_prim_minimum_spanning_tree failed");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_nodes  = CNT_W'(1);
    fail_count = 0;
    quiet_in   = 1'b0;
    quiet_out  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_node_after_reset();
    test_fill_matrix();
    test_node_count_clamp();
    test_weight_extremes();
    test_equal_weights();
    test_disconnected_graph();
    test_random_traffic();

    settle_block();
    if (fail_count == 0) begin
      $display("tb_prim_minimum_spanning_tree passed");
    end else begin
      $display("tb_prim_minimum_spanning_tree failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/pmst_pkg.sv
sv/pmst_ram.sv
sv/pmst_seq.sv
sv/pmst_dp.sv
sv/prim_minimum_spanning_tree.sv
verif/tb_prim_minimum_spanning_tree.sv
